@@ design/tgr_pkg.sv @@
`timescale 1ns / 1ps

package tgr_pkg;

	// Font geometry.
	localparam int FONT_CHARS  = 256;
	localparam int GLYPH_ROWS  = 16;
	localparam int GLYPH_WIDTH = 8;
	localparam int STORE_DEPTH = 4096;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int ROW_W       = $clog2(GLYPH_ROWS);
	localparam int PAIRS       = GLYPH_WIDTH / 2;
	localparam int PAIR_W      = $clog2(PAIRS);

	// Field widths.
	localparam int CODE_W   = 8;
	localparam int FROW_W   = 4;
	localparam int BITS_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int COLOUR_W = 32;
	localparam int PITCH_W  = 16;
	localparam int CURSOR_W = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Request kinds and control characters.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_RENDER = 1'b1;
	localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
	localparam logic [CODE_W-1:0] CODE_LF = 8'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 8'd3;

	// Configuration reset values.
	localparam logic [ADDR_W-1:0]   FRAME_BASE_RESET  = 32'h0000_0000;
	localparam logic [PITCH_W-1:0]  LINE_PITCH_RESET  = 16'd3200;
	localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RESET = 32'h00FF_FFFF;
	localparam logic [COLOUR_W-1:0] BACK_COLOUR_RESET = 32'h0000_0000;

	// Microcode step address.
	typedef logic [3:0] step_t;

	localparam step_t ST_FETCH    = 4'd0;
	localparam step_t ST_IS_LOAD  = 4'd1;
	localparam step_t ST_IS_CR    = 4'd2;
	localparam step_t ST_IS_LF    = 4'd3;
	localparam step_t ST_MUL      = 4'd4;
	localparam step_t ST_ADD_PROD = 4'd5;
	localparam step_t ST_ADD_CX   = 4'd6;
	localparam step_t ST_ROW      = 4'd7;
	localparam step_t ST_EMIT     = 4'd8;
	localparam step_t ST_ADVANCE  = 4'd9;
	localparam step_t ST_LOAD     = 4'd10;
	localparam step_t ST_CR       = 4'd11;
	localparam step_t ST_LF       = 4'd12;

	// Datapath operation selected by a control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL,
		OP_ADD_PROD,
		OP_ADD_CX,
		OP_ROW,
		OP_EMIT,
		OP_ADVANCE,
		OP_LOAD,
		OP_CR,
		OP_LF
	} op_t;

	// Sequencing condition of a control word.
	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_WAIT_REQ,
		C_IF_LOAD,
		C_IF_CR,
		C_IF_LF,
		C_EMIT
	} cond_t;

	typedef struct packed {
		logic  take;
		op_t   op;
		cond_t cond;
		step_t target;
	} ctl_t;

	// The control program.
	function automatic ctl_t ucode(step_t s);
		ctl_t w;
		w = '{take: 1'b0, op: OP_NONE, cond: C_JUMP, target: ST_FETCH};
		case (s)
			ST_FETCH:    w = '{1'b1, OP_NONE,     C_WAIT_REQ, ST_FETCH};
			ST_IS_LOAD:  w = '{1'b0, OP_NONE,     C_IF_LOAD,  ST_LOAD};
			ST_IS_CR:    w = '{1'b0, OP_NONE,     C_IF_CR,    ST_CR};
			ST_IS_LF:    w = '{1'b0, OP_NONE,     C_IF_LF,    ST_LF};
			ST_MUL:      w = '{1'b0, OP_MUL,      C_NEXT,     ST_FETCH};
			ST_ADD_PROD: w = '{1'b0, OP_ADD_PROD, C_NEXT,     ST_FETCH};
			ST_ADD_CX:   w = '{1'b0, OP_ADD_CX,   C_NEXT,     ST_FETCH};
			ST_ROW:      w = '{1'b0, OP_ROW,      C_NEXT,     ST_FETCH};
			ST_EMIT:     w = '{1'b0, OP_EMIT,     C_EMIT,     ST_ROW};
			ST_ADVANCE:  w = '{1'b0, OP_ADVANCE,  C_JUMP,     ST_FETCH};
			ST_LOAD:     w = '{1'b0, OP_LOAD,     C_JUMP,     ST_FETCH};
			ST_CR:       w = '{1'b0, OP_CR,       C_JUMP,     ST_FETCH};
			ST_LF:       w = '{1'b0, OP_LF,       C_JUMP,     ST_FETCH};
			default:     w = '{1'b0, OP_NONE,     C_JUMP,     ST_FETCH};
		endcase
		return w;
	endfunction

	// Font store entry of one glyph row.
	function automatic logic [STORE_AW-1:0] font_addr(logic [CODE_W-1:0] code,
		logic [FROW_W-1:0] row);
		logic [31:0] sum;
		sum = 32'(code) * 32'(GLYPH_ROWS) + 32'(row);
		return sum[STORE_AW-1:0];
	endfunction

endpackage

@@ design/tgr_req_if.sv @@
`timescale 1ns / 1ps

interface tgr_req_if import tgr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CODE_W-1:0] char_code;
	logic [FROW_W-1:0] font_row;
	logic [BITS_W-1:0] font_bits;

	modport source (output valid, req_type, char_code, font_row, font_bits, input ready);
	modport sink (input valid, req_type, char_code, font_row, font_bits, output ready);
endinterface

@@ design/tgr_pix_if.sv @@
`timescale 1ns / 1ps

interface tgr_pix_if import tgr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   pixel_addr;
	logic [COLOUR_W-1:0] left_colour;
	logic [COLOUR_W-1:0] right_colour;
	logic                last;

	modport source (output valid, pixel_addr, left_colour, right_colour, last, input ready);
	modport sink (input valid, pixel_addr, left_colour, right_colour, last, output ready);
endinterface

@@ design/tgr_cfg_if.sv @@
`timescale 1ns / 1ps

interface tgr_cfg_if import tgr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/tgr_ram.sv @@
`timescale 1ns / 1ps

module tgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/text_glyph_renderer.sv @@
`timescale 1ns / 1ps
// Bitmap font character generator for a 32-bit-per-pixel framebuffer.
// The req channel carries font loads (req_type 0: char_code, font_row, font_bits)
// and characters to draw (req_type 1: char_code). The cfg channel writes frame_base,
// line_pitch, text_colour and back_colour by index 0 to 3; it is always ready and
// should be used only while the block is idle. The pix channel returns the pixel pairs
// of each glyph: 64 pairs per glyph, rows top to bottom, last set on the final pair.
// Carriage return and line feed move the cursor and draw nothing.
// A microcoded sequencer steps a small control program; each request is taken at the
// fetch step. A glyph runs setup steps (fetch, three decode steps, one 16x16 multiply,
// two adds), then 16 rows of one row fetch step and four emit steps each, then one
// step to advance the cursor. The output register holds a pair until it is taken; the
// sequencer waits in its emit step while the receiver stalls, losing no pair.
// Reset clears the cursor, restores the register defaults and returns the sequencer to
// its fetch step. The font store is not cleared and must be loaded before use.
module text_glyph_renderer import tgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tgr_req_if.sink   req,
	tgr_pix_if.source pix,
	tgr_cfg_if.sink   cfg
);

	// Sequencer state.
	step_t step_q;
	step_t step_next;
	ctl_t  ctl;

	// Configuration registers.
	logic [ADDR_W-1:0]   frame_base_q;
	logic [PITCH_W-1:0]  line_pitch_q;
	logic [COLOUR_W-1:0] text_colour_q;
	logic [COLOUR_W-1:0] back_colour_q;

	// Cursor.
	logic [CURSOR_W-1:0] cursor_x_q;
	logic [CURSOR_W-1:0] cursor_y_q;

	// Latched request.
	logic              type_q;
	logic [CODE_W-1:0] code_q;
	logic [FROW_W-1:0] frow_q;
	logic [BITS_W-1:0] fbits_q;

	// Datapath registers.
	logic [ADDR_W-1:0] prod_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ROW_W-1:0]  row_q;
	logic [PAIR_W-1:0] pair_q;
	logic [BITS_W-1:0] bits_q;
	logic              last_row_q;

	// Output register.
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [COLOUR_W-1:0] out_left_q;
	logic [COLOUR_W-1:0] out_right_q;
	logic                out_last_q;

	// Font store ports.
	logic                font_we;
	logic [STORE_AW-1:0] font_waddr;
	logic [STORE_AW-1:0] font_raddr;
	logic [BITS_W-1:0]   font_rdata;

	logic req_fire;
	logic out_free;
	logic emit_fire;
	logic pair_last;
	logic code_ok;
	logic load_ok;
	logic [ADDR_W-1:0] row_step;

	assign ctl       = ucode(step_q);
	assign req.ready = ctl.take;
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && ctl.take;
	assign out_free  = !out_valid_q || pix.ready;
	assign emit_fire = (ctl.op == OP_EMIT) && out_free;
	assign pair_last = (pair_q == PAIR_W'(PAIRS - 1));
	assign code_ok   = ({1'b0, code_q} < 9'(FONT_CHARS));
	assign load_ok   = code_ok && ({1'b0, frow_q} < 5'(GLYPH_ROWS));
	assign row_step  = {{(ADDR_W - PITCH_W){1'b0}}, line_pitch_q[PITCH_W-1:2], 2'b00};

	// Next step of the control program.
	always_comb begin
		step_next = step_q + 4'd1;
		case (ctl.cond)
			C_NEXT:     step_next = step_q + 4'd1;
			C_JUMP:     step_next = ctl.target;
			C_WAIT_REQ: step_next = req_fire ? step_q + 4'd1 : step_q;
			C_IF_LOAD:  step_next = (type_q == REQ_LOAD) ? ctl.target : step_q + 4'd1;
			C_IF_CR:    step_next = (code_q == CODE_CR) ? ctl.target : step_q + 4'd1;
			C_IF_LF:    step_next = (code_q == CODE_LF) ? ctl.target : step_q + 4'd1;
			C_EMIT: begin
				if (!(emit_fire && pair_last)) begin
					step_next = step_q;
				end else if (!last_row_q) begin
					step_next = ctl.target;
				end else begin
					step_next = step_q + 4'd1;
				end
			end
			default:    step_next = ST_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

	// Configuration writes; indexes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= FRAME_BASE_RESET;
			line_pitch_q  <= LINE_PITCH_RESET;
			text_colour_q <= TEXT_COLOUR_RESET;
			back_colour_q <= BACK_COLOUR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_BASE:  frame_base_q  <= cfg.data;
				REG_LINE_PITCH:  line_pitch_q  <= cfg.data[PITCH_W-1:0];
				REG_TEXT_COLOUR: text_colour_q <= cfg.data;
				REG_BACK_COLOUR: back_colour_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Cursor updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else begin
			case (ctl.op)
				OP_CR:      cursor_x_q <= '0;
				OP_LF: begin
					cursor_x_q <= '0;
					cursor_y_q <= cursor_y_q + CURSOR_W'(GLYPH_ROWS);
				end
				OP_ADVANCE: cursor_x_q <= cursor_x_q + CURSOR_W'(GLYPH_WIDTH);
				default: ;
			endcase
		end
	end

	// Request latch and glyph datapath.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_q  <= req.req_type;
			code_q  <= req.char_code;
			frow_q  <= req.font_row;
			fbits_q <= req.font_bits;
		end
		case (ctl.op)
			OP_MUL: begin
				prod_q <= 32'(cursor_y_q) * 32'(line_pitch_q);
				row_q  <= '0;
			end
			OP_ADD_PROD: base_q <= frame_base_q + prod_q;
			OP_ADD_CX:   base_q <= base_q + {{(ADDR_W - CURSOR_W - 2){1'b0}}, cursor_x_q, 2'b00};
			OP_ROW: begin
				// The store has been reading this row since the previous step.
				bits_q     <= code_ok ? font_rdata : '0;
				last_row_q <= (row_q == ROW_W'(GLYPH_ROWS - 1));
				row_q      <= row_q + ROW_W'(1);
				addr_q     <= base_q;
				base_q     <= base_q + row_step;
				pair_q     <= '0;
			end
			OP_EMIT: begin
				if (out_free) begin
					addr_q <= addr_q + ADDR_W'(8);
					pair_q <= pair_q + PAIR_W'(1);
					bits_q <= {bits_q[BITS_W-3:0], 2'b00};
				end
			end
			default: ;
		endcase
	end

	// Output register: loaded by the emit step whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_addr_q  <= addr_q;
			out_left_q  <= bits_q[BITS_W-1] ? text_colour_q : back_colour_q;
			out_right_q <= bits_q[BITS_W-2] ? text_colour_q : back_colour_q;
			out_last_q  <= last_row_q && pair_last;
		end
	end

	assign pix.valid        = out_valid_q;
	assign pix.pixel_addr   = out_addr_q;
	assign pix.left_colour  = out_left_q;
	assign pix.right_colour = out_right_q;
	assign pix.last         = out_last_q;

	// Font store.
	assign font_we    = (ctl.op == OP_LOAD) && load_ok;
	assign font_waddr = font_addr(code_q, frow_q);
	assign font_raddr = font_addr(code_q, FROW_W'(row_q));

	tgr_ram #(
		.WIDTH (BITS_W),
		.DEPTH (STORE_DEPTH)
	) u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (fbits_q),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

endmodule
